/* sv/sprm_pkg.sv */
// Package: shared types, constants and command/status structs for the swap page manager.
`default_nettype none
package sprm_pkg;
  localparam int unsigned PageSlotsDef = 4096;
  localparam int unsigned PageBytesDef = 4096;
  localparam int unsigned MaxEvict = 63;
  localparam logic [12:0] LimitReset = 13'd4096;
  localparam logic [12:0] MaxResReset = 13'd64;

  typedef enum logic [2:0] {
    KIND_ALLOC  = 3'd0,
    KIND_FREE   = 3'd1,
    KIND_READ   = 3'd2,
    KIND_WRITE  = 3'd3,
    KIND_LOCK   = 3'd4,
    KIND_UNLOCK = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_INVALID  = 2'd2,
    ST_NOROOM   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_LIMIT  = 1'b0,
    CFG_MAXRES = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_DECIDE, S_SCAN, S_SCANRD, S_EVICT, S_EVWAIT,
    S_APPLY, S_DONE, S_DWAIT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic lookup;
    logic scan_start;
    logic scan_step;
    logic evict;
    logic apply;
    logic complete;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic early_done;
    logic need_load;
    logic must_evict;
    logic scan_hit;
    logic scan_end;
  } sts_t;
endpackage
`default_nettype wire

/* sv/sprm_ctrl.sv */
// Controller: sequences clearing, lookup, victim scan, eviction and completion.
`default_nettype none
module sprm_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire sprm_pkg::sts_t sts,
  output sprm_pkg::cmd_t cmd,
  output logic in_rdy
);
  import sprm_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_rdy = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.early_done || !sts.need_load) state_next = S_APPLY;
        else if (sts.must_evict) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCANRD;
        end else state_next = S_APPLY;
      end
      S_SCANRD: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.scan_hit) state_next = S_EVICT;
        else if (sts.scan_end) state_next = S_APPLY;
        else begin
          cmd.scan_step = 1'b1;
          state_next = S_SCANRD;
        end
      end
      S_EVICT: begin
        if (out_free) begin
          cmd.evict = 1'b1;
          state_next = S_EVWAIT;
        end
      end
      S_EVWAIT: begin
        if (sts.must_evict) begin
          cmd.scan_step = 1'b1;
          state_next = S_SCANRD;
        end else state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.complete = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* sv/sprm_dp.sv */
// Datapath: page state memory, counters, victim scan pointer and result register.
`default_nettype none
module sprm_dp #(
  parameter int unsigned PAGE_SLOTS = sprm_pkg::PageSlotsDef,
  parameter int unsigned PAGE_BYTES = sprm_pkg::PageBytesDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sprm_pkg::cmd_t cmd,
  output sprm_pkg::sts_t sts,
  input  wire logic [2:0] kind,
  input  wire logic [15:0] handle,
  input  wire logic [31:0] size_bytes,
  input  wire logic cfg_fire,
  input  wire logic [0:0] cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic res_take,
  output logic res_valid,
  output logic is_eviction,
  output logic [12:0] page_id,
  output logic needs_writeback,
  output logic [23:0] backing_offset,
  output logic fetched,
  output logic [1:0] status,
  output logic [12:0] new_handle,
  output logic last
);
  import sprm_pkg::*;
  localparam int AW = $clog2(PAGE_SLOTS);
  localparam int PSH = $clog2(PAGE_BYTES);
  localparam int CW = AW + 1;

  // per page: {freed, resident, dirty, locked}
  logic [3:0] mem [PAGE_SLOTS];
  logic [3:0] rd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [3:0] wr_data;
  logic wr_en;
  logic [CW-1:0] clr_ptr;

  logic [12:0] swap_limit, max_res;
  logic started;
  logic [CW-1:0] issued, res_count;
  logic [2:0] k;
  logic [15:0] h;
  logic [31:0] sz;
  logic [20:0] need;
  logic early;
  logic [1:0] early_st;
  logic [12:0] early_nh;
  logic hit_res;
  logic [3:0] hent;
  logic [CW-1:0] scan_id;
  logic [5:0] ev_cnt;
  logic [CW-1:0] hidx;
  logic [21:0] tot;
  logic loaded;

  assign hidx = h[CW-1:0];
  assign need = 21'(({1'b0, sz} + 33'(PAGE_BYTES - 1)) >> PSH);
  assign tot = 22'(issued) + 22'(need);

  always_comb begin
    rd_addr = AW'(scan_id - 1'b1);
    if (cmd.capture) rd_addr = AW'(handle[CW-1:0] - 1'b1);
    else if (cmd.scan_start) rd_addr = AW'(issued - 1'b1);
    else if (cmd.scan_step) rd_addr = AW'(scan_id - 2'd2);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = AW'(hidx - 1'b1);
    wr_data = hent;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
      wr_addr = clr_ptr[AW-1:0];
      wr_data = '0;
    end else if (cmd.evict) begin
      wr_en = 1'b1;
      wr_addr = AW'(scan_id - 1'b1);
      wr_data = {rd[3], 1'b0, 1'b0, rd[0]};
    end else if (cmd.apply && !early) begin
      wr_en = 1'b1;
      unique case (k)
        KIND_FREE: wr_data = 4'b1000;
        KIND_READ: wr_data = {hent[3], 1'b1, hent[1:0]};
        KIND_WRITE: wr_data = {hent[3], 1'b1, 1'b1, hent[0]};
        KIND_LOCK: wr_data = {hent[3], 1'b1, hent[1], 1'b1};
        default: wr_data = {hent[3:1], 1'b0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  assign loaded = !hent[2];
  assign sts.clear_done = (clr_ptr == CW'(PAGE_SLOTS - 1));
  assign sts.early_done = early;
  assign sts.need_load = (k == KIND_READ || k == KIND_WRITE || k == KIND_LOCK) && loaded;
  assign sts.must_evict = (res_count >= CW'(max_res)) && (ev_cnt != 6'(MaxEvict));
  assign sts.scan_hit = rd[2] && !rd[0] && (scan_id != '0);
  assign sts.scan_end = (scan_id <= CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
      swap_limit <= LimitReset;
      max_res <= MaxResReset;
      started <= 1'b0;
      issued <= '0;
      res_count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_ptr <= clr_ptr + 1'b1;
      if (cfg_fire) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LIMIT: swap_limit <= cfg_data;
          default: max_res <= cfg_data;
        endcase
      end
      if (res_take) res_valid <= 1'b0;
      if (cmd.capture) begin
        k <= kind;
        h <= handle;
        sz <= size_bytes;
        ev_cnt <= '0;
      end
      if (cmd.lookup) begin
        early <= 1'b1;
        early_nh <= '0;
        if (k == KIND_ALLOC) begin
          started <= 1'b1;
          if (sz == '0) early_st <= ST_INVALID;
          else if (tot > 22'(swap_limit) || tot > 22'(PAGE_SLOTS))
            early_st <= ST_NOROOM;
          else begin
            early_st <= ST_OK;
            issued <= CW'(tot);
            early_nh <= 13'(tot);
          end
        end else if (k > KIND_UNLOCK || !started) early_st <= ST_INVALID;
        else if (h == '0 || h > 16'(issued) || rd[3]) early_st <= ST_NOTFOUND;
        else begin
          early <= 1'b0;
          early_st <= ST_OK;
        end
        hent <= rd;
      end
      if (cmd.scan_start) scan_id <= issued;
      else if (cmd.scan_step) scan_id <= scan_id - 1'b1;
      if (cmd.evict) begin
        res_valid <= 1'b1;
        is_eviction <= 1'b1;
        page_id <= 13'(scan_id);
        needs_writeback <= rd[1];
        backing_offset <= 24'(scan_id - 1'b1) << PSH;
        fetched <= 1'b0;
        status <= ST_OK;
        new_handle <= '0;
        last <= 1'b0;
        res_count <= res_count - 1'b1;
        ev_cnt <= ev_cnt + 1'b1;
        if (scan_id == hidx) hent <= {hent[3], 1'b0, 1'b0, hent[0]};
      end
      if (cmd.apply && !early) begin
        if (k == KIND_FREE && hent[2]) res_count <= res_count - 1'b1;
        else if (sts.need_load) res_count <= res_count + 1'b1;
      end
      if (cmd.complete) begin
        res_valid <= 1'b1;
        is_eviction <= 1'b0;
        needs_writeback <= 1'b0;
        status <= early ? early_st : ST_OK;
        new_handle <= early ? early_nh : '0;
        last <= 1'b1;
        if (!early && sts.need_load) begin
          page_id <= 13'(h);
          backing_offset <= 24'(hidx - 1'b1) << PSH;
          fetched <= 1'b1;
        end else begin
          page_id <= '0;
          backing_offset <= '0;
          fetched <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* sv/swap_page_residency_manager.sv */
// Sequencing: a result follows acceptance after the lookup, any victim scan and each eviction,
// plus any output stall.
// Flow: one transaction at a time; the victim scan walks page ids downward through the
// page state memory read port.
// Reset: synchronous; afterward a clearing pass zeroes every entry of the page state
// memory while no transaction is accepted (configuration writes are still taken).
`default_nettype none
module swap_page_residency_manager #(
  parameter int unsigned PAGE_SLOTS = sprm_pkg::PageSlotsDef,
  parameter int unsigned PAGE_BYTES = sprm_pkg::PageBytesDef
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] kind,
  input  wire logic [15:0] handle,
  input  wire logic [31:0] size_bytes,
  output logic out_valid,
  input  wire logic out_ready,
  output logic is_eviction,
  output logic [12:0] page_id,
  output logic needs_writeback,
  output logic [23:0] backing_offset,
  output logic fetched,
  output logic [1:0] status,
  output logic [12:0] new_handle,
  output logic last
);
  import sprm_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic in_fire, res_take, out_free;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign res_take = out_valid && out_ready;
  assign out_free = !out_valid || out_ready;

  sprm_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .sts, .cmd, .in_rdy(in_ready)
  );

  sprm_dp #(.PAGE_SLOTS(PAGE_SLOTS), .PAGE_BYTES(PAGE_BYTES)) u_dp (
    .clk, .rst, .cmd, .sts, .kind, .handle, .size_bytes,
    .cfg_fire(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .res_take, .res_valid(out_valid), .is_eviction, .page_id, .needs_writeback,
    .backing_offset, .fetched, .status, .new_handle, .last
  );

  a_evict_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_eviction |-> !last && !fetched) else $error("eviction marked last");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.evict && !cmd.complete) else $error("accept while busy");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    cmd.complete |=> out_valid && last) else $error("completion missing");
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for swap_page_residency_manager: directed and random requests checked against a predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sprm_pkg::*;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [31:0] size;
  } req_t;

  typedef struct packed {
    logic        evict;
    logic [12:0] pid;
    logic        wb;
    logic [23:0] off;
    logic        fetched;
    logic [1:0]  st;
    logic [12:0] newh;
    logic        last;
  } resp_t;

  localparam int WatchLimit = 60000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic [2:0] kind = '0;
  logic [15:0] handle = '0;
  logic [31:0] size_bytes = '0;
  logic out_valid, out_ready = 1'b0;
  logic is_eviction, needs_writeback, fetched, last;
  logic [12:0] page_id, new_handle;
  logic [23:0] backing_offset;
  logic [1:0] status;

  swap_page_residency_manager dut (.*);

  always #4 clk = ~clk;

  // predictor state
  int unsigned lim_pages = LimitReset, res_limit = MaxResReset;
  bit          has_started;
  int unsigned issued, resident_cnt;
  bit          freed_m[4096], res_m[4096], dirty_m[4096], lock_m[4096];
  resp_t       outcome_q[$];
  req_t        pending[$];
  int          errors, n_items, n_results, n_evictions;

  function automatic resp_t mk(bit ev, int unsigned id, bit wb, bit fe, status_t st,
                               int unsigned nh);
    resp_t r;
    r.evict = ev; r.pid = id[12:0]; r.wb = wb;
    r.off = (id == 0) ? 24'd0 : 24'((id - 1) * PageBytesDef);
    r.fetched = fe; r.st = st; r.newh = nh[12:0]; r.last = !ev;
    return r;
  endfunction

  function automatic int unsigned newest_unlocked();
    for (int unsigned id = issued; id >= 1; id--)
      if (res_m[id-1] && !lock_m[id-1]) return id;
    return 0;
  endfunction

  function automatic bit bring_in(int unsigned id);
    int unsigned v;
    int cnt = 0;
    if (res_m[id-1]) return 0;
    while (resident_cnt >= res_limit && cnt < MaxEvict) begin
      v = newest_unlocked();
      if (v == 0) break;
      outcome_q.push_back(mk(1, v, dirty_m[v-1], 0, ST_OK, 0));
      cnt++;
      dirty_m[v-1] = 0; res_m[v-1] = 0; resident_cnt--;
    end
    res_m[id-1] = 1; resident_cnt++;
    return 1;
  endfunction

  function automatic void predict_request(req_t q);
    longint unsigned need;
    int unsigned h = q.handle;
    bit fe = 0;
    if (q.kind == KIND_ALLOC) begin
      has_started = 1;
      if (q.size == 0) begin
        outcome_q.push_back(mk(0, 0, 0, 0, ST_INVALID, 0)); return;
      end
      need = (longint'(q.size) + PageBytesDef - 1) / PageBytesDef;
      if (issued + need > lim_pages || issued + need > PageSlotsDef) begin
        outcome_q.push_back(mk(0, 0, 0, 0, ST_NOROOM, 0)); return;
      end
      issued += int'(need);
      outcome_q.push_back(mk(0, 0, 0, 0, ST_OK, issued)); return;
    end
    if (q.kind > KIND_UNLOCK || !has_started) begin
      outcome_q.push_back(mk(0, 0, 0, 0, ST_INVALID, 0)); return;
    end
    if (h == 0 || h > issued || freed_m[h-1]) begin
      outcome_q.push_back(mk(0, 0, 0, 0, ST_NOTFOUND, 0)); return;
    end
    case (q.kind)
      KIND_FREE: begin
        if (res_m[h-1]) resident_cnt--;
        freed_m[h-1] = 1; res_m[h-1] = 0; dirty_m[h-1] = 0; lock_m[h-1] = 0;
      end
      KIND_READ: fe = bring_in(h);
      KIND_WRITE: begin
        fe = bring_in(h); dirty_m[h-1] = 1;
      end
      KIND_LOCK: begin
        fe = bring_in(h); lock_m[h-1] = 1;
      end
      default: lock_m[h-1] = 0;
    endcase
    outcome_q.push_back(mk(0, fe ? h : 0, 0, fe, ST_OK, 0));
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(pending.pop_front());
        n_items++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          in_valid <= 1'b1;
          kind <= pending[0].kind;
          handle <= pending[0].handle;
          size_bytes <= pending[0].size;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: pattern stalls plus one long hold-off on request
  bit hold_request, hold_done;
  int hold_cnt, rx_cycle, rx_mode;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_request && !hold_done) begin
      hold_done = 1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    $display("tb: mismatch on %s at %0t: got %0d expected %0d", what, $realtime, got, want);
    errors++;
  endtask

  // monitor
  resp_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (is_eviction) n_evictions++;
      if (outcome_q.size() == 0) begin
        flag_mismatch("unexpected transaction", page_id, 0);
      end else begin
        want = outcome_q.pop_front();
        if (is_eviction !== want.evict) flag_mismatch("is_eviction", is_eviction, want.evict);
        if (page_id !== want.pid) flag_mismatch("page_id", page_id, want.pid);
        if (needs_writeback !== want.wb)
          flag_mismatch("needs_writeback", needs_writeback, want.wb);
        if (backing_offset !== want.off)
          flag_mismatch("backing_offset", backing_offset, want.off);
        if (fetched !== want.fetched) flag_mismatch("fetched", fetched, want.fetched);
        if (status !== want.st) flag_mismatch("status", status, want.st);
        if (new_handle !== want.newh) flag_mismatch("new_handle", new_handle, want.newh);
        if (last !== want.last) flag_mismatch("last", last, want.last);
      end
    end
  end

  // watchdog
  int quiet;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WatchLimit) begin
      $display("tb: timeout with %0d results outstanding", outcome_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [12:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_LIMIT) lim_pages = v; else res_limit = v;
  endtask

  task automatic settle();
    while (pending.size() > 0 || in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic void add(logic [2:0] k, int unsigned h, longint unsigned s);
    req_t q;
    q.kind = k; q.handle = h[15:0]; q.size = s[31:0];
    pending.push_back(q);
  endfunction

  int unsigned est_issued;
  function automatic void add_random(int count);
    int unsigned r, h;
    est_issued = issued;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) h = $urandom();
      else h = $urandom_range(0, est_issued + 2);
      if (r < 14) begin
        case ($urandom_range(0, 9))
          0: add(KIND_ALLOC, 0, 0);
          1: add(KIND_ALLOC, 0, $urandom());
          default: add(KIND_ALLOC, 0, $urandom_range(1, 3 * PageBytesDef));
        endcase
        est_issued += 2;
      end else if (r < 19) add(KIND_FREE, h, $urandom());
      else if (r < 47) add(KIND_READ, h, $urandom());
      else if (r < 72) add(KIND_WRITE, h, $urandom());
      else if (r < 84) add(KIND_LOCK, h, $urandom());
      else if (r < 97) add(KIND_UNLOCK, h, $urandom());
      else add(3'($urandom_range(6, 7)), h, $urandom());
    end
  endfunction

  initial begin
    int unsigned b;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // not started, zero size, size extremes, unknown pages and kinds
    add(KIND_READ, 1, 0);
    add(KIND_FREE, 1, 0);
    add(3'd7, 1, 0);
    add(KIND_ALLOC, 0, 0);
    add(KIND_ALLOC, 0, 1);
    add(KIND_ALLOC, 0, PageBytesDef);
    add(KIND_ALLOC, 0, PageBytesDef + 1);
    add(KIND_ALLOC, 0, 32'hFFFF_FFFF);
    add(KIND_READ, 0, 0);
    add(KIND_READ, 16'hFFFF, 0);
    add(KIND_READ, 5, 0);
    add(KIND_READ, 4, 0);
    add(KIND_READ, 4, 0);
    add(KIND_WRITE, 4, 0);
    add(KIND_LOCK, 3, 0);
    add(KIND_UNLOCK, 3, 0);
    add(KIND_FREE, 4, 0);
    add(KIND_READ, 4, 0);
    add(3'd6, 2, 32'hFFFF_FFFF);
    add_random(60);
    settle();

    // every resident page locked: load goes above the limit
    write_reg(CFG_MAXRES, 13'd4);
    b = issued;
    add(KIND_ALLOC, 0, 6 * PageBytesDef);
    for (int i = 1; i <= 5; i++) add(KIND_LOCK, b + i, 0);
    add(KIND_READ, b + 6, 0);
    for (int i = 1; i <= 5; i++) add(KIND_UNLOCK, b + i, 0);
    add_random(60);
    settle();

    write_reg(CFG_LIMIT, 13'd300);
    write_reg(CFG_MAXRES, 13'd16);
    hold_request = 1;
    add_random(100);
    settle();

    // many residents, then a tiny limit hits the eviction cap
    write_reg(CFG_LIMIT, 13'd4096);
    write_reg(CFG_MAXRES, 13'd4096);
    b = issued;
    add(KIND_ALLOC, 0, 100 * PageBytesDef);
    settle();
    for (int i = 1; i <= 90; i++) add(($urandom_range(0, 1) ? KIND_WRITE : KIND_READ), b + i, 0);
    settle();
    write_reg(CFG_MAXRES, 13'd1);
    add(KIND_READ, b + 95, 0);
    add(KIND_WRITE, b + 96, 0);
    add_random(60);
    settle();

    write_reg(CFG_LIMIT, 13'd1);
    add(KIND_ALLOC, 0, 1);
    add_random(60);
    settle();

    write_reg(CFG_LIMIT, 13'd2000);
    write_reg(CFG_MAXRES, 13'd8);
    add_random(40);
    settle();
    repeat (100) @(posedge clk);

    if (outcome_q.size() > 0) begin
      $display("tb: %0d expected results never arrived", outcome_q.size());
      errors++;
    end
    $display("tb: %0d requests, %0d results, %0d evictions, %0d pages issued",
             n_items, n_results, n_evictions, issued);
    $display("tb: limits swept from 1 to 4096, including lock-all and eviction cap cases");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
sv/sprm_pkg.sv
sv/sprm_ctrl.sv
sv/sprm_dp.sv
sv/swap_page_residency_manager.sv
dv/tb.sv
